### hw/rtl/pnd_pkg.sv
// shared widths and constants of the packed normal decoder
// no dependencies
package pnd_pkg;

  localparam int WordW    = 32;
  localparam int XyW      = 11;
  localparam int ZW       = 10;
  localparam int CompW    = 16;
  localparam int QBits    = 16;
  localparam int ScaledW  = 21;
  localparam int SquareW  = 41;
  localparam int ResW     = 78;
  localparam int FracSh   = 32;
  localparam int XyScale  = (1 << 10) - 1;
  localparam int ZScale   = (1 << 9) - 1;
  localparam int Lanes    = 3;
  localparam logic [QBits-1:0] QMaxPos = QBits'((1 << 15) - 1);

endpackage

### hw/rtl/pnd_in_if.sv
// input channel: one packed normal word per item
// depends on pnd_pkg
interface pnd_in_if;
  logic                        valid;
  logic                        ready;
  logic [pnd_pkg::WordW-1:0]   packed_normal;

  modport source (output valid, output packed_normal, input ready);
  modport sink   (input valid, input packed_normal, output ready);
endinterface

### hw/rtl/pnd_out_if.sv
// output channel: one unit vector in q1.15 per item
// depends on pnd_pkg
interface pnd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pnd_pkg::CompW-1:0]   unit_x;
  logic signed [pnd_pkg::CompW-1:0]   unit_y;
  logic signed [pnd_pkg::CompW-1:0]   unit_z;
  logic                               zero_length;

  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output zero_length, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                  input zero_length, output ready);
endinterface

### hw/rtl/packed_normal_decode_normalize_top.sv
// packed 11/11/10 normal decoder with unit-length normalization
// depends on pnd_pkg, pnd_in_if, pnd_out_if
//
// in_i takes one packed word per item (x bits 0-10, y 11-21, z 22-31,
// two's complement). out_o gives one item per input: x, y, z of the
// normalized vector in signed q1.15, rounded to nearest, +1.0 saturated
// to 32767, and zero_length set with zero components for an all-zero word.
// Throughput is one item per cycle unless out_o stalls. An accepted item
// passes one input register, a constant scale stage, a square stage, a
// sum stage, sixteen compare-subtract stages that resolve one result bit
// each for all three components, and the output register.
// The whole pipeline advances as one; when the receiver holds ready low
// with a result waiting, every stage holds and in_i.ready drops, nothing
// is lost or repeated. Bubbles move along with their valid bits.
// Reset clears all valid bits; no item is in flight after reset.
module packed_normal_decode_normalize_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pnd_in_if.sink      in_i,
  pnd_out_if.source   out_o
);

  localparam int RW = pnd_pkg::ResW;
  localparam int NL = pnd_pkg::Lanes;
  localparam int NQ = pnd_pkg::QBits;

  logic adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // input register
  logic                      v1_q;
  logic [pnd_pkg::WordW-1:0] w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q <= in_i.packed_normal;
    end
  end

  // sign extend and bring to a common denominator
  logic                               v2_q;
  logic signed [pnd_pkg::ScaledW-1:0] c_q [NL];
  logic signed [pnd_pkg::XyW-1:0]     fx, fy;
  logic signed [pnd_pkg::ZW-1:0]      fz;

  assign fx = w_q[10:0];
  assign fy = w_q[21:11];
  assign fz = w_q[31:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= pnd_pkg::ScaledW'(fx) * pnd_pkg::ScaledW'(pnd_pkg::ZScale);
      c_q[1] <= pnd_pkg::ScaledW'(fy) * pnd_pkg::ScaledW'(pnd_pkg::ZScale);
      c_q[2] <= pnd_pkg::ScaledW'(fz) * pnd_pkg::ScaledW'(pnd_pkg::XyScale);
    end
  end

  // squares
  logic                       v3_q;
  logic [pnd_pkg::SquareW-1:0] sq_q [NL];
  logic [NL-1:0]               neg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg3_q <= {c_q[2][pnd_pkg::ScaledW-1], c_q[1][pnd_pkg::ScaledW-1],
                 c_q[0][pnd_pkg::ScaledW-1]};
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[l] <= pnd_pkg::SquareW'(c_q[l]) * pnd_pkg::SquareW'(c_q[l]);
      end
    end
  end

  // iteration stages: index 0 is the init stage
  logic                 iv_q   [NQ+1];
  logic                 izero_q[NQ+1];
  logic signed [RW-1:0] is_q   [NQ+1];
  logic signed [RW-1:0] ir_q   [NQ+1][NL];
  logic signed [RW-1:0] ip_q   [NQ+1][NL];
  logic [NQ-1:0]        iq_q   [NQ+1][NL];
  logic [NL-1:0]        ineg_q [NQ+1];

  logic signed [RW-1:0] sum_s;
  assign sum_s = RW'(sq_q[0]) + RW'(sq_q[1]) + RW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q[0] <= 1'b0;
    end else if (adv) begin
      iv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      is_q[0]    <= sum_s;
      izero_q[0] <= (sum_s == '0);
      ineg_q[0]  <= neg3_q;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_init
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ir_q[0][l] <= (RW'(sq_q[l]) <<< pnd_pkg::FracSh) - sum_s;
        ip_q[0][l] <= -sum_s;
        iq_q[0][l] <= '0;
      end
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_it
    localparam int K = NQ - 1 - j;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        iv_q[j+1] <= 1'b0;
      end else if (adv) begin
        iv_q[j+1] <= iv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        is_q[j+1]    <= is_q[j];
        izero_q[j+1] <= izero_q[j];
        ineg_q[j+1]  <= ineg_q[j];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_ln
      logic signed [RW-1:0] d;
      logic                 take;
      assign d    = (ip_q[j][l] <<< (K + 2)) + (is_q[j] <<< (2 * K + 2));
      assign take = (ir_q[j][l] >= d);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (take) begin
            ir_q[j+1][l] <= ir_q[j][l] - d;
            ip_q[j+1][l] <= ip_q[j][l] + (is_q[j] <<< (K + 1));
            iq_q[j+1][l] <= iq_q[j][l] | (NQ'(1) << K);
          end else begin
            ir_q[j+1][l] <= ir_q[j][l];
            ip_q[j+1][l] <= ip_q[j][l];
            iq_q[j+1][l] <= iq_q[j][l];
          end
        end
      end
    end
  end

  // sign, saturation and output register
  logic [pnd_pkg::CompW-1:0] res [NL];

  for (genvar l = 0; l < NL; l++) begin : g_res
    logic [NQ-1:0] qf;
    assign qf = iq_q[NQ][l];
    always_comb begin
      if (izero_q[NQ]) begin
        res[l] = '0;
      end else if (ineg_q[NQ][l]) begin
        res[l] = pnd_pkg::CompW'(-qf);
      end else if (qf > pnd_pkg::QMaxPos) begin
        res[l] = pnd_pkg::QMaxPos;
      end else begin
        res[l] = qf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (adv) begin
      out_o.valid <= iv_q[NQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.unit_x      <= res[0];
      out_o.unit_y      <= res[1];
      out_o.unit_z      <= res[2];
      out_o.zero_length <= izero_q[NQ];
    end
  end

endmodule

### hw/rtl/pnd_checker.sv
// port-level checks for the packed normal decoder
// depends on pnd_pkg; bound to packed_normal_decode_normalize_top
module pnd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_ready_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [pnd_pkg::CompW-1:0]  unit_x_i,
  input  logic signed [pnd_pkg::CompW-1:0]  unit_y_i,
  input  logic signed [pnd_pkg::CompW-1:0]  unit_z_i,
  input  logic                              zero_length_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("item shown during reset");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_length_i |-> unit_x_i == '0 && unit_y_i == '0 && unit_z_i == '0)
    else $error("zero length item with nonzero components");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i || !out_valid_i |-> in_ready_i)
    else $error("input held while output free");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(unit_x_i)
      && $stable(unit_y_i) && $stable(unit_z_i) && $stable(zero_length_i))
    else $error("stalled item changed");

endmodule

bind packed_normal_decode_normalize_top pnd_checker u_pnd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .unit_x_i     (out_o.unit_x),
  .unit_y_i     (out_o.unit_y),
  .unit_z_i     (out_o.unit_z),
  .zero_length_i(out_o.zero_length)
);
